>>> hw/rtl/pfc_pkg.sv
package pfc_pkg;

  // Square geometry and letter coding (A=0 .. Z=25)
  localparam int SIDE    = 5;
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;
  localparam int TDATA_W = 16;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] rc_t;
  typedef logic [5:0] pos_t;

  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_Z = letter_t'(LETTERS - 1);

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_END,
    KIND_ENC,
    KIND_DEC
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOOK,
    ST_CELL
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic key_wr;
    logic walk_clr;
    logic walk_step;
    logic set_complete;
    logic pair_load;
    logic cell_load;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic key_complete;
    logic walk_last;
  } sts_t;

  // Pair letter: saturate out-of-range codes to Z, then fold J onto I.
  function automatic letter_t fold_pair(letter_t v);
    letter_t r;
    r = (v > LETTER_Z) ? LETTER_Z : v;
    if (r == LETTER_J) begin
      r = LETTER_I;
    end
    return r;
  endfunction

  // One step along a row or column, wrapping round the square.
  function automatic rc_t rc_step(rc_t v, logic dec);
    rc_t r;
    if (dec) begin
      r = (v == '0) ? rc_t'(SIDE - 1) : v - rc_t'(1);
    end else begin
      r = (v == rc_t'(SIDE - 1)) ? '0 : v + rc_t'(1);
    end
    return r;
  endfunction

  // Cell index row * 5 + column, the multiply done as shift and add.
  function automatic letter_t cell_index(rc_t r, rc_t c);
    return letter_t'({r, 2'b00}) + letter_t'(r) + letter_t'(c);
  endfunction

endpackage

>>> hw/rtl/pfc_ctrl.sv
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  kind_t in_kind,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  sts_t  sts,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   in_beat;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          case (in_kind)
            KIND_END: state_nxt = sts.key_complete ? ST_IDLE : ST_WALK;
            KIND_ENC: state_nxt = ST_LOOK;
            KIND_DEC: state_nxt = ST_LOOK;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (sts.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOK: state_nxt = ST_CELL;
      ST_CELL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.key_wr    = in_beat && (in_kind == KIND_KEY);
        cmd.walk_clr  = in_beat && (in_kind == KIND_END);
        cmd.pair_load = in_beat && ((in_kind == KIND_ENC) || (in_kind == KIND_DEC));
      end
      ST_WALK: begin
        cmd.walk_step    = 1'b1;
        cmd.set_complete = sts.walk_last;
      end
      ST_LOOK: cmd.cell_load = 1'b1;
      ST_CELL: cmd.out_load  = out_free;
      default: cmd = '0;
    endcase
  end

  // Output valid: set on load, cleared once the beat is taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // A result only appears after the square read of a pair
  a_out_from_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_CELL)
    else $error("result raised outside the cell read");

endmodule

>>> hw/rtl/pfc_datapath.sv
module pfc_datapath
  import pfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  output sts_t    sts,
  input  letter_t in_letter_a,
  input  letter_t in_letter_b,
  input  logic    in_dec,
  output letter_t out_first,
  output letter_t out_second,
  output logic    out_square_ready
);

  logic [LETTERS-1:0] used_r, used_nxt;
  letter_t fill_r, fill_nxt;
  rc_t     row_r, row_nxt;
  rc_t     col_r, col_nxt;
  letter_t walk_r, walk_nxt;
  logic    complete_r, complete_nxt;
  logic    dec_r;

  pos_t    pos_mem [LETTERS];
  letter_t sq_mem  [CELLS];
  pos_t    pos_a_r, pos_b_r;
  letter_t sq_x_r, sq_y_r;
  letter_t out_first_r, out_second_r;
  logic    out_ready_r;

  letter_t wr_letter;
  logic    wr_ok;
  logic    place;
  rc_t     r1, c1, r2, c2;
  letter_t idx_x, idx_y;

  assign sts.key_complete = complete_r;
  assign sts.walk_last    = (walk_r == LETTER_Z);

  // Letter to place: a key letter with J folded, or the walk letter
  always_comb begin
    if (cmd.walk_step) begin
      wr_letter = walk_r;
      wr_ok     = (walk_r != LETTER_J);
    end else begin
      wr_letter = (in_letter_a == LETTER_J) ? LETTER_I : in_letter_a;
      wr_ok     = cmd.key_wr && !complete_r && (in_letter_a <= LETTER_Z);
    end
    place = wr_ok && !used_r[wr_letter] && (fill_r < letter_t'(CELLS));
  end

  // Fill position, used marks, walk counter and completion flag
  always_comb begin
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    walk_nxt     = walk_r;
    complete_nxt = complete_r || cmd.set_complete;
    if (place) begin
      used_nxt[wr_letter] = 1'b1;
      fill_nxt            = fill_r + letter_t'(1);
      if (col_r == rc_t'(SIDE - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + rc_t'(1);
      end else begin
        col_nxt = col_r + rc_t'(1);
      end
    end
    if (cmd.walk_clr) begin
      walk_nxt = '0;
    end else if (cmd.walk_step) begin
      walk_nxt = walk_r + letter_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      fill_r     <= '0;
      row_r      <= '0;
      col_r      <= '0;
      walk_r     <= '0;
      complete_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      walk_r     <= walk_nxt;
      complete_r <= complete_nxt;
    end
  end

  // Position table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (place) begin
      pos_mem[wr_letter] <= {row_r, col_r};
    end
    if (cmd.pair_load) begin
      pos_a_r <= pos_mem[fold_pair(in_letter_a)];
      pos_b_r <= pos_mem[fold_pair(in_letter_b)];
      dec_r   <= in_dec;
    end
  end

  // Playfair rule on the two positions
  always_comb begin
    r1 = pos_a_r[5:3];
    c1 = pos_a_r[2:0];
    r2 = pos_b_r[5:3];
    c2 = pos_b_r[2:0];
    if (r1 == r2) begin
      idx_x = cell_index(r1, rc_step(c1, dec_r));
      idx_y = cell_index(r2, rc_step(c2, dec_r));
    end else if (c1 == c2) begin
      idx_x = cell_index(rc_step(r1, dec_r), c1);
      idx_y = cell_index(rc_step(r2, dec_r), c2);
    end else begin
      idx_x = cell_index(r1, c2);
      idx_y = cell_index(r2, c1);
    end
  end

  // Key square: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (place) begin
      sq_mem[fill_r] <= wr_letter;
    end
    if (cmd.cell_load) begin
      sq_x_r <= sq_mem[idx_x];
      sq_y_r <= sq_mem[idx_y];
    end
  end

  // Output register; letters read as zero until the square is complete
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_first_r  <= complete_r ? sq_x_r : '0;
      out_second_r <= complete_r ? sq_y_r : '0;
      out_ready_r  <= complete_r;
    end
  end

  assign out_first        = out_first_r;
  assign out_second       = out_second_r;
  assign out_square_ready = out_ready_r;

  // Every placed letter is marked used exactly once
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(fill_r))
    else $error("used marks disagree with fill count");

  // Row and column track the fill count
  a_fill_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == cell_index(row_r, col_r))
    else $error("fill position out of step");

  // The end-of-key walk always completes the square
  a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_complete |=> (fill_r == letter_t'(CELLS)) && complete_r)
    else $error("square not full after walk");

endmodule

>>> hw/rtl/playfair_digraph_cipher_core.sv
// Key letter: taken while idle. End of key: a walk over A..Z unless the square is complete.
// Pair: position table read at the accept edge, then key square read, then output register,
// which waits while the output is held; a new item is taken only after that register loads.
// The next item is taken while a result still waits on the output.
// Synchronous active-low reset clears the used marks, fill count and completion
// flag; square and position tables are left unset until written.
module playfair_digraph_cipher_core
  import pfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [4:0] letter_a, [9:5] letter_b, rest zero
  input  logic [1:0]         in_tuser,   // [1:0] kind
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [4:0] out_first, [9:5] out_second, rest zero
  output logic               out_tuser   // [0] square_ready
);

  cmd_t    cmd;
  sts_t    sts;
  kind_t   in_kind;
  letter_t first, second;

  assign in_kind = kind_t'(in_tuser);

  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_kind),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pfc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_letter_a      (in_tdata[4:0]),
    .in_letter_b      (in_tdata[9:5]),
    .in_dec           (in_kind == KIND_DEC),
    .out_first        (first),
    .out_second       (second),
    .out_square_ready (out_tuser)
  );

  // Pack the result letters, zero padding to whole bytes
  assign out_tdata = {{(TDATA_W - 10){1'b0}}, second, first};

endmodule

>>> sim/playfair_digraph_cipher_core_tb.sv
`timescale 1ns / 100ps

module playfair_digraph_cipher_core_tb;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PAIRS = 630;

  // One enciphered or deciphered pair as it leaves the block.
  typedef struct {
    letter_t first;
    letter_t second;
    logic    ready;
  } digraph_t;

  // Keeps its own key square, predicts each pair and checks the block's output.
  class playfair_scoreboard;
    letter_t  key_square[CELLS];
    int       row_at[LETTERS];
    int       col_at[LETTERS];
    bit       placed[LETTERS];
    int       n_placed;
    bit       square_done;
    digraph_t expected_pairs[$];
    int       errors;

    function new();
      for (int l = 0; l < LETTERS; l++) begin
        placed[l] = 1'b0;
      end
      n_placed    = 0;
      square_done = 1'b0;
      errors      = 0;
    endfunction

    // Append a letter to the square unless it is already there or the square is full.
    function void place_letter(int l);
      if (placed[l] || n_placed >= CELLS) begin
        return;
      end
      key_square[n_placed] = letter_t'(l);
      row_at[l]            = n_placed / SIDE;
      col_at[l]            = n_placed % SIDE;
      placed[l]            = 1'b1;
      n_placed++;
    endfunction

    // Pair letters saturate to Z and have J folded onto I.
    function int clean_letter(letter_t v);
      int l;
      l = (v > LETTER_Z) ? int'(LETTER_Z) : int'(v);
      if (l == int'(LETTER_J)) begin
        l = int'(LETTER_I);
      end
      return l;
    endfunction

    function letter_t square_at(int r, int c);
      return key_square[(r % SIDE) * SIDE + (c % SIDE)];
    endfunction

    // Update the square for an accepted beat and queue the pair it produces, if any.
    function void take_item(kind_t k, letter_t a, letter_t b);
      digraph_t d;
      int       la, lb, r1, c1, r2, c2, shift;
      case (k)
        KIND_KEY: begin
          if (!square_done && a < LETTERS) begin
            place_letter((a == LETTER_J) ? int'(LETTER_I) : int'(a));
          end
        end
        KIND_END: begin
          if (!square_done) begin
            for (int l = 0; l < LETTERS; l++) begin
              if (l != int'(LETTER_J)) begin
                place_letter(l);
              end
            end
            square_done = 1'b1;
          end
        end
        default: begin
          if (!square_done) begin
            d.first  = '0;
            d.second = '0;
            d.ready  = 1'b0;
          end else begin
            la    = clean_letter(a);
            lb    = clean_letter(b);
            r1    = row_at[la];
            c1    = col_at[la];
            r2    = row_at[lb];
            c2    = col_at[lb];
            shift = (k == KIND_ENC) ? 1 : SIDE - 1;
            if (r1 == r2) begin
              d.first  = square_at(r1, c1 + shift);
              d.second = square_at(r2, c2 + shift);
            end else if (c1 == c2) begin
              d.first  = square_at(r1 + shift, c1);
              d.second = square_at(r2 + shift, c2);
            end else begin
              d.first  = square_at(r1, c2);
              d.second = square_at(r2, c1);
            end
            d.ready = 1'b1;
          end
          expected_pairs.insert(expected_pairs.size(), d);
        end
      endcase
    endfunction

    // Compare an output beat with the oldest predicted pair.
    function void check_pair(letter_t first, letter_t second, logic ready);
      digraph_t d;
      if (expected_pairs.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected pair: first=%0d second=%0d ready=%b", first, second, ready);
        end
        return;
      end
      d = expected_pairs.pop_front();
      if (first !== d.first || second !== d.second || ready !== d.ready) begin
        errors++;
        if (errors <= 10) begin
          $display("pair mismatch: expected first=%0d second=%0d ready=%b, got %0d %0d %b",
                   d.first, d.second, d.ready, first, second, ready);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic [1:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  playfair_scoreboard sb;
  int                 burst_left;
  int                 cycles;
  int                 recv_cycle;
  logic [15:0]        ready_mask;

  playfair_digraph_cipher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Give up if the run hangs.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // The receiver takes its ready from a 16-bit mask that is walked round and redrawn with random bits.
  initial begin
    out_tready = 1'b0;
    ready_mask = 16'hFFFF;
    recv_cycle = 0;
    forever begin
      @(negedge clk);
      if (recv_cycle % 40 == 0) begin
        ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      out_tready <= ready_mask[recv_cycle % 16];
      recv_cycle++;
    end
  end

  // Every accepted output beat is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_pair(letter_t'(out_tdata[4:0]), letter_t'(out_tdata[9:5]), out_tuser);
    end
  end

  // Drive one beat, wait for it to be taken, then perhaps end the burst with a gap.
  task automatic send_item(kind_t k, letter_t a, letter_t b);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {6'b0, b, a};
    do @(posedge clk); while (!in_tready);
    sb.take_item(k, a, b);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender off until every predicted pair has come out.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_pairs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Choose a pair that shares a row, shares a column, or is arbitrary, with J now and then.
  task automatic pick_pair(output letter_t a, output letter_t b);
    int mode, r1, r2, c1, c2;
    mode = $urandom_range(0, 2);
    r1   = $urandom_range(0, SIDE - 1);
    c1   = $urandom_range(0, SIDE - 1);
    r2   = (mode == 0) ? r1 : $urandom_range(0, SIDE - 1);
    c2   = (mode == 1) ? c1 : $urandom_range(0, SIDE - 1);
    if (mode == 2) begin
      a = letter_t'($urandom_range(0, 31));
      b = letter_t'($urandom_range(0, 31));
    end else begin
      a = sb.key_square[r1 * SIDE + c1];
      b = sb.key_square[r2 * SIDE + c2];
    end
    if (a == LETTER_I && $urandom_range(0, 1) == 1) begin
      a = LETTER_J;
    end
    if (b == LETTER_I && $urandom_range(0, 1) == 1) begin
      b = LETTER_J;
    end
  endtask

  initial begin
    letter_t a, b;
    kind_t   k;
    int      sent;
    bit      paused;

    sb         = new();
    burst_left = 4;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_KEY;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pairs before the square is complete come back as zeros.
    send_item(KIND_ENC, letter_t'(7), letter_t'(3));
    // Key with J folded, a repeated letter and out-of-range codes.
    send_item(KIND_KEY, letter_t'(15), '0);
    send_item(KIND_KEY, letter_t'(11), '0);
    send_item(KIND_KEY, letter_t'(0), '0);
    send_item(KIND_DEC, letter_t'(31), letter_t'(31));
    send_item(KIND_KEY, letter_t'(24), '0);
    send_item(KIND_KEY, letter_t'(5), '0);
    send_item(KIND_KEY, LETTER_J, letter_t'(31));
    send_item(KIND_KEY, letter_t'(17), '0);
    send_item(KIND_KEY, letter_t'(26), '0);
    send_item(KIND_KEY, letter_t'(15), '0);
    send_item(KIND_KEY, letter_t'(31), '0);
    send_item(KIND_KEY, letter_t'(25), '0);
    send_item(KIND_END, '0, '0);
    // Key items after completion are ignored.
    send_item(KIND_KEY, letter_t'(3), '0);
    send_item(KIND_END, letter_t'(31), letter_t'(31));
    // Shared row, shared column, rectangle, repeated letter, J and saturation.
    send_item(KIND_ENC, sb.key_square[0], sb.key_square[4]);
    send_item(KIND_DEC, sb.key_square[5], sb.key_square[9]);
    send_item(KIND_ENC, sb.key_square[2], sb.key_square[22]);
    send_item(KIND_DEC, sb.key_square[1], sb.key_square[21]);
    send_item(KIND_ENC, sb.key_square[0], sb.key_square[24]);
    send_item(KIND_DEC, sb.key_square[6], sb.key_square[18]);
    send_item(KIND_ENC, sb.key_square[12], sb.key_square[12]);
    send_item(KIND_DEC, LETTER_J, sb.key_square[13]);
    send_item(KIND_ENC, letter_t'(26), letter_t'(0));

    // Random pairs with the odd ignored key item thrown in.
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_PAIRS) begin
      if ($urandom_range(0, 15) == 0) begin
        k = ($urandom_range(0, 1) == 1) ? KIND_END : KIND_KEY;
        send_item(k, letter_t'($urandom_range(0, 31)), letter_t'($urandom_range(0, 31)));
      end else begin
        pick_pair(a, b);
        k = ($urandom_range(0, 1) == 1) ? KIND_DEC : KIND_ENC;
        send_item(k, a, b);
        sent++;
      end
      if (!paused && sent == RANDOM_PAIRS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> playfair_digraph_cipher_core.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_ctrl.sv
hw/rtl/pfc_datapath.sv
hw/rtl/playfair_digraph_cipher_core.sv
sim/playfair_digraph_cipher_core_tb.sv
